[src/byte_stuff_framer_checksum_unit_assert.svh]
// Assertion helpers for the framer. They refer to i_clk and i_rst_n of the
// module that includes this file.
`ifndef BYTE_STUFF_FRAMER_CHECKSUM_UNIT_ASSERT_SVH
`define BYTE_STUFF_FRAMER_CHECKSUM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BSF_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");
`define BSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");
`else
`define BSF_ASSERT_HOLDS(lbl, ante, cons)
`define BSF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/bsf_pkg.sv]
package bsf_pkg;

    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_CHAR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR = 1'b1;

    localparam logic [7:0] FLAG_CHAR_RESET   = 8'd36;
    localparam logic [7:0] ESCAPE_CHAR_RESET = 8'd47;

    typedef struct packed {
        logic [7:0] flag_char;
        logic [7:0] escape_char;
    } t_cfg;

    // One classified payload byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
        logic       need_open;
        logic       need_esc;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OPEN,
        BK_ESC,
        BK_DATA,
        BK_CLOSE
    } t_back_state;

endpackage

[src/byte_stuff_framer_checksum_unit.sv]
// Byte-stuffing flag framer with an 8-bit checksum trailer. Each input beat
// carries one payload byte and a last-of-frame mark; the block sends out the
// opening flag before the first byte of a frame, an escape before any byte
// equal to the flag or escape character, the byte itself, and after the last
// byte the closing flag together with the inverted modulo-256 sum of every
// byte sent in the frame (flags and escapes included). The output link moves
// one byte per cycle while not stalled, so one input beat puts one to four
// bytes on it: the byte itself, plus one each for an opening flag, an escape
// and a closing flag. That output sequencer sets the rate; the input side
// keeps taking beats into a small queue while the sequencer is busy or the
// output is stalled. Flag and escape characters are to be written through the
// configuration port only while the block is idle, which it does not enforce.
`include "byte_stuff_framer_checksum_unit_assert.svh"

module byte_stuff_framer_checksum_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Input channel: a beat is taken when valid is high and stall is low.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_frame_last,

    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_frame_done,
    output logic [7:0]                    o_trailer,

    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    bsf_pkg::t_cfg      r_cfg;
    bsf_pkg::t_cfg      n_cfg;
    bsf_pkg::t_q_status q_status;
    bsf_pkg::t_item     push_item;
    bsf_pkg::t_item     head_item;
    logic               push;
    logic               pop;

    // Registers are always writable; writes are to be issued only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                bsf_pkg::REG_FLAG_CHAR:   n_cfg.flag_char   = i_cfg_data;
                bsf_pkg::REG_ESCAPE_CHAR: n_cfg.escape_char = i_cfg_data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_char   <= bsf_pkg::FLAG_CHAR_RESET;
            r_cfg.escape_char <= bsf_pkg::ESCAPE_CHAR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front tracks whether a frame is open and marks which bytes need
    // an opening flag or an escape, so the back only has to sequence them.
    bsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_cfg        (r_cfg),
        .i_status     (q_status),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_item       (push_item)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // The back emits one byte per cycle, while it has queued work and the output
    // is not stalled, into a registered output stage and keeps the running sum of the open frame.
    bsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_status     (q_status),
        .i_item       (head_item),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .o_trailer    (o_trailer)
    );

    // The closing flag always ends the run of its input beat.
    `BSF_ASSERT_HOLDS(a_done_ends_run, o_out_valid && o_frame_done, o_run_last)
    // The closing flag carries the configured flag character.
    `BSF_ASSERT_HOLDS(a_done_is_flag, o_out_valid && o_frame_done, o_out_byte == r_cfg.flag_char)
    // Only the closing flag carries a trailer.
    `BSF_ASSERT_HOLDS(a_trailer_zero, o_out_valid && !o_frame_done, o_trailer == 8'd0)
    // A stalled output beat stays on the port unchanged.
    `BSF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte))

endmodule

[src/bsf_front.sv]
module bsf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_last,
    input  bsf_pkg::t_cfg    i_cfg,
    input  bsf_pkg::t_q_status i_status,
    output logic             o_stall,
    output logic             o_push,
    output bsf_pkg::t_item   o_item
);

    logic r_in_frame;
    logic n_in_frame;

    assign o_stall = i_status.full;
    assign o_push  = i_valid && !i_status.full;

    always_comb begin
        o_item.data_byte  = i_data_byte;
        o_item.frame_last = i_frame_last;
        o_item.need_open  = !r_in_frame;
        o_item.need_esc   = (i_data_byte == i_cfg.flag_char) ||
                            (i_data_byte == i_cfg.escape_char);
    end

    // A frame stays open until a beat marked last has been taken.
    assign n_in_frame = o_push ? !i_frame_last : r_in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule

[src/bsf_queue.sv]
module bsf_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bsf_pkg::t_item     i_item,
    input  logic               i_pop,
    output bsf_pkg::t_item     o_item,
    output bsf_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsf_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_count;

    assign o_status.empty = (r_count == CW'(0));
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_item         = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

[src/bsf_back.sv]
module bsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bsf_pkg::t_cfg      i_cfg,
    input  bsf_pkg::t_q_status i_status,
    input  bsf_pkg::t_item     i_item,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_frame_done,
    output logic [7:0]         o_trailer
);

    bsf_pkg::t_back_state r_state;
    bsf_pkg::t_back_state n_state;
    bsf_pkg::t_item       r_item;
    logic [7:0]           r_sum;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_run_last;
    logic                 r_done;
    logic [7:0]           r_trailer;

    logic                 adv;
    logic                 piece_done;
    logic                 item_done;
    logic [7:0]           emit_byte;
    logic                 emit_run_last;
    logic                 emit_done;
    logic [7:0]           sum_add;
    logic [7:0]           emit_trailer;

    // First byte that a freshly loaded entry puts on the line.
    function automatic bsf_pkg::t_back_state first_piece(input bsf_pkg::t_item item);
        bsf_pkg::t_back_state s;
        if (item.need_open) begin
            s = bsf_pkg::BK_OPEN;
        end else if (item.need_esc) begin
            s = bsf_pkg::BK_ESC;
        end else begin
            s = bsf_pkg::BK_DATA;
        end
        return s;
    endfunction

    assign adv = !r_valid || !i_out_stall;

    // Output decode for the current state.
    always_comb begin
        emit_byte     = r_item.data_byte;
        emit_run_last = 1'b0;
        emit_done     = 1'b0;
        case (r_state)
            bsf_pkg::BK_OPEN: begin
                emit_byte = i_cfg.flag_char;
            end
            bsf_pkg::BK_ESC: begin
                emit_byte = i_cfg.escape_char;
            end
            bsf_pkg::BK_DATA: begin
                emit_byte     = r_item.data_byte;
                emit_run_last = !r_item.frame_last;
            end
            bsf_pkg::BK_CLOSE: begin
                emit_byte     = i_cfg.flag_char;
                emit_run_last = 1'b1;
                emit_done     = 1'b1;
            end
            default: begin
                emit_byte = r_item.data_byte;
            end
        endcase
        sum_add      = (r_state == bsf_pkg::BK_OPEN) ? emit_byte : r_sum + emit_byte;
        emit_trailer = emit_done ? ~sum_add : 8'd0;
        piece_done   = (r_state != bsf_pkg::BK_IDLE) && adv;
        item_done    = piece_done && emit_run_last;
        o_pop        = !i_status.empty && ((r_state == bsf_pkg::BK_IDLE) || item_done);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsf_pkg::BK_IDLE: begin
                if (o_pop) begin
                    n_state = first_piece(i_item);
                end
            end
            bsf_pkg::BK_OPEN: begin
                if (adv) begin
                    n_state = r_item.need_esc ? bsf_pkg::BK_ESC : bsf_pkg::BK_DATA;
                end
            end
            bsf_pkg::BK_ESC: begin
                if (adv) begin
                    n_state = bsf_pkg::BK_DATA;
                end
            end
            bsf_pkg::BK_DATA: begin
                if (adv) begin
                    if (r_item.frame_last) begin
                        n_state = bsf_pkg::BK_CLOSE;
                    end else if (o_pop) begin
                        n_state = first_piece(i_item);
                    end else begin
                        n_state = bsf_pkg::BK_IDLE;
                    end
                end
            end
            bsf_pkg::BK_CLOSE: begin
                if (adv) begin
                    n_state = o_pop ? first_piece(i_item) : bsf_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = bsf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsf_pkg::BK_IDLE;
            r_valid <= 1'b0;
            r_sum   <= 8'd0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_valid <= piece_done;
            end
            if (piece_done) begin
                r_sum <= emit_done ? 8'd0 : sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (piece_done) begin
            r_byte     <= emit_byte;
            r_run_last <= emit_run_last;
            r_done     <= emit_done;
            r_trailer  <= emit_trailer;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_done = r_done;
    assign o_trailer    = r_trailer;

endmodule

[sim/tb.sv]
module tb;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 58;
    localparam int LONG_HOLD        = 150;
    localparam int TAIL_CYCLES      = 32;
    localparam int SHOWN_MISMATCHES = 10;

    // Short names for the register indexes used in the table.
    localparam logic [bsf_pkg::CFG_IDX_W-1:0] FLAG_REG = bsf_pkg::REG_FLAG_CHAR;
    localparam logic [bsf_pkg::CFG_IDX_W-1:0] ESC_REG  = bsf_pkg::REG_ESCAPE_CHAR;

    // A row of the directed table is either a payload beat or a register write.
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // For payload rows, n > 0 means the output bytes e0..e(n-1) and the trailer
    // are typed in by hand; n == 0 leaves the row to the framing predictor.
    typedef struct packed {
        t_row_kind                     kind;
        logic [bsf_pkg::CFG_IDX_W-1:0] idx;
        logic [7:0]                    val;
        logic                          last;
        logic [2:0]                    n;
        logic [7:0]                    e0, e1, e2, e3;
        logic [7:0]                    trl;
    } t_row;

    // One beat of the framed output stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
        logic [7:0] trailer;
    } t_beat;

    localparam t_row DIR_ROWS [25] = '{
        // Reset characters '$' and '/': a one-byte frame, then a frame that
        // walks the byte extremes and escapes both special characters.
        '{ROW_ITEM, FLAG_REG, 8'h41, 1'b1, 3'd3, 8'h24, 8'h41, 8'h24, 8'h00, 8'h76},
        '{ROW_ITEM, FLAG_REG, 8'h00, 1'b0, 3'd2, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'hFF, 1'b0, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h24, 1'b0, 3'd2, 8'h2F, 8'h24, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h2F, 1'b1, 3'd3, 8'h2F, 8'h2F, 8'h24, 8'h00, 8'h07},
        // Flag at zero and escape at all ones.
        '{ROW_CFG,  FLAG_REG, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_CFG,  ESC_REG,  8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h00, 1'b0, 3'd3, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'hFF, 1'b1, 3'd3, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02},
        // Flag equal to the escape: one escape only, four beats in all.
        '{ROW_CFG,  FLAG_REG, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'hFF, 1'b1, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03},
        '{ROW_ITEM, FLAG_REG, 8'h80, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h01, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // New characters, then a flag change while a frame is still open.
        '{ROW_CFG,  FLAG_REG, 8'h7E, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_CFG,  ESC_REG,  8'h7D, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h7E, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h7D, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_CFG,  FLAG_REG, 8'h55, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h55, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h7E, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // Escape at zero.
        '{ROW_CFG,  FLAG_REG, 8'h24, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_CFG,  ESC_REG,  8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_ITEM, FLAG_REG, 8'h2F, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{ROW_CFG,  ESC_REG,  8'h2F, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [7:0]                    i_data_byte;
    logic                          i_frame_last;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [7:0]                    o_out_byte;
    logic                          o_run_last;
    logic                          o_frame_done;
    logic [7:0]                    o_trailer;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bsf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]                    i_cfg_data;

    // Directed row that the payload on the input port belongs to, -1 for random
    // beats. It is driven together with the payload so the checker sees it at
    // the accepting edge.
    int item_row;

    // Framer state as the predictor sees it.
    logic [7:0] flag_now;
    logic [7:0] esc_now;
    logic       frame_open;
    logic [7:0] frame_sum;

    t_beat framed_q[$];

    int  mismatches    = 0;
    int  beats_checked = 0;
    int  bytes_taken   = 0;
    int  frames_closed = 0;
    int  escapes_sent  = 0;
    int  reg_writes    = 0;
    int  cycles        = 0;
    bit  calm          = 1'b0;
    int  in_gap_pct    = 0;
    int  out_gap_pct   = 0;
    bit  long_hold_req = 1'b0;

    byte_stuff_framer_checksum_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .o_trailer    (o_trailer),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding.",
                     cycles, framed_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_beat plain_beat(input logic [7:0] value);
        return '{value, 1'b0, 1'b0, 8'h00};
    endfunction

    // Frames one payload byte: opening flag when no frame is open, escape when
    // the byte matches either special character, the byte, and on the last
    // byte the closing flag carrying the inverted sum of the whole frame.
    task automatic frame_byte(input logic [7:0] data, input logic last, input bit keep);
        t_beat run[$];
        t_beat b;
        if (!frame_open) begin
            frame_sum  = 8'h00;
            frame_open = 1'b1;
            frame_sum  = frame_sum + flag_now;
            run = {run, plain_beat(flag_now)};
        end
        if (data == flag_now || data == esc_now) begin
            frame_sum = frame_sum + esc_now;
            run = {run, plain_beat(esc_now)};
            escapes_sent++;
        end
        frame_sum = frame_sum + data;
        run = {run, plain_beat(data)};
        if (last) begin
            frame_sum    = frame_sum + flag_now;
            b.out_byte   = flag_now;
            b.run_last   = 1'b0;
            b.frame_done = 1'b1;
            b.trailer    = ~frame_sum;
            run = {run, b};
            frame_open = 1'b0;
            frame_sum  = 8'h00;
            frames_closed++;
        end
        run[run.size() - 1].run_last = 1'b1;
        if (keep) begin
            foreach (run[k]) framed_q = {framed_q, run[k]};
        end
    endtask

    // Queues the hand-typed beats of a directed row.
    task automatic queue_typed(input t_row r);
        logic [7:0] e [4];
        t_beat      b;
        e = '{r.e0, r.e1, r.e2, r.e3};
        for (int k = 0; k < int'(r.n); k++) begin
            b.out_byte   = e[k];
            b.run_last   = (k == int'(r.n) - 1);
            b.frame_done = r.last && (k == int'(r.n) - 1);
            b.trailer    = b.frame_done ? r.trl : 8'h00;
            framed_q = {framed_q, b};
        end
    endtask

    task automatic report(input string what, input t_beat want, input t_beat got);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
            $display("%0s at cycle %0d: expected byte %02h last %0b done %0b trailer %02h,",
                     what, cycles, want.out_byte, want.run_last, want.frame_done,
                     want.trailer);
            $display("    got byte %02h last %0b done %0b trailer %02h",
                     got.out_byte, got.run_last, got.frame_done, got.trailer);
        end
    endtask

    // Checker. Everything sampled here holds its value from before the edge,
    // since the stimulus is driven with nonblocking assignments.
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bsf_pkg::REG_FLAG_CHAR) begin
                    flag_now = i_cfg_data;
                end else begin
                    esc_now = i_cfg_data;
                end
                reg_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                bytes_taken++;
                if (item_row >= 0 && DIR_ROWS[item_row].n != 3'd0) begin
                    frame_byte(i_data_byte, i_frame_last, 1'b0);
                    queue_typed(DIR_ROWS[item_row]);
                end else begin
                    frame_byte(i_data_byte, i_frame_last, 1'b1);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_byte, o_run_last, o_frame_done, o_trailer};
                beats_checked++;
                if (framed_q.size() == 0) begin
                    report("Unexpected output beat", '0, got);
                end else begin
                    want = framed_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                        got.frame_done !== want.frame_done ||
                        got.trailer !== want.trailer) begin
                        report("Output mismatch", want, got);
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request so the
    // input queue fills and the block stalls its sender.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
                n = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one payload beat, possibly after an idle burst, and returns at
    // the edge that accepts it. Valid stays high into the next beat.
    task automatic offer(input logic [7:0] data, input logic last, input int row);
        int n;
        if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
            n = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_frame_last <= last;
        item_row     <= row;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops offering and waits until every queued output beat has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (framed_q.size() != 0);
    endtask

    task automatic write_reg(input logic [bsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] f;
        logic [7:0] e;
        logic [7:0] d;
        int         left;

        flag_now   = bsf_pkg::FLAG_CHAR_RESET;
        esc_now    = bsf_pkg::ESCAPE_CHAR_RESET;
        frame_open = 1'b0;
        frame_sum  = 8'h00;
        left       = 0;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'h00;
        i_frame_last <= 1'b0;
        item_row     <= -1;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= bsf_pkg::REG_FLAG_CHAR;
        i_cfg_data   <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, with light idling on both sides.
        in_gap_pct  = 20;
        out_gap_pct = 5;
        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                settle();
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].val);
            end else begin
                offer(DIR_ROWS[r].val, DIR_ROWS[r].last, r);
            end
        end

        // Random phases. Frames may stay open across a phase boundary, so the
        // register writes there also land in the middle of a frame.
        for (int p = 0; p < PHASES; p++) begin
            calm        = (p == PHASES - 1);
            in_gap_pct  = calm ? 0 : 10 * $urandom_range(0, 3);
            out_gap_pct = calm ? 0 : 4 * $urandom_range(0, 3);
            settle();
            case (p)
                1:       begin f = 8'hFF;          e = 8'h00;          end
                2:       begin f = 8'h00;          e = 8'h00;          end
                PHASES - 1: begin
                    f = bsf_pkg::FLAG_CHAR_RESET;
                    e = bsf_pkg::ESCAPE_CHAR_RESET;
                end
                default: begin
                    f = 8'($urandom_range(0, 255));
                    e = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(bsf_pkg::REG_FLAG_CHAR, f);
            write_reg(bsf_pkg::REG_ESCAPE_CHAR, e);
            if (p == 3) long_hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (left == 0) begin
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                       : $urandom_range(1, 6);
                end
                case ($urandom_range(0, 9))
                    0, 1:    d = f;
                    2, 3:    d = e;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                left--;
                offer(d, left == 0, -1);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Framed %0d payload bytes into %0d output beats: %0d frames closed, %0d escapes.",
                 bytes_taken, beats_checked, frames_closed, escapes_sent);
        $display("Register writes: %0d, including flag equal to escape and a %0d-cycle hold-off.",
                 reg_writes, LONG_HOLD);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d output beats failed their check.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/bsf_pkg.sv
src/bsf_front.sv
src/bsf_queue.sv
src/bsf_back.sv
src/byte_stuff_framer_checksum_unit.sv
sim/tb.sv
